[rtl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants of the linear probing hash map: hash constants,
// result status codes, request kinds and the state machine encodings.
// ----------------------------------------------------------------------------
package lph_pkg;

  // Table geometry and hash constants
  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned ValW        = 64;
  localparam int unsigned HalfW       = 32;
  localparam int unsigned HashShift   = 32;
  localparam logic [KeyW-1:0] HashMul = 64'hff51afd7ed558ccd;
  localparam int unsigned QueueDepth  = 2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_MISS       = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_UPDATED    = 3'd3,
    ST_ZERO_VALUE = 3'd4,
    ST_FULL       = 3'd5,
    ST_ZERO_KEY   = 3'd6
  } status_e;

  // Request class decided by the front end
  typedef enum logic [1:0] {
    K_PROBE    = 2'd0,
    K_ZERO_KEY = 2'd1,
    K_ZERO_VAL = 2'd2
  } kind_e;

  // Request as it travels from front end to back end
  typedef struct packed {
    kind_e            kind;
    logic             mode;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
  } req_t;

  // Front end states
  typedef enum logic [2:0] {
    F_IDLE = 3'd0,
    F_MUL0 = 3'd1,
    F_MUL1 = 3'd2,
    F_MUL2 = 3'd3,
    F_PUSH = 3'd4
  } front_state_e;

  // Back end states
  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_CHECK = 2'd2
  } back_state_e;

endpackage

[rtl/lph_front.sv]
// ----------------------------------------------------------------------------
// lph_front
// Accepts requests, classifies them and computes the home slot with one
// shared 32x32 multiplier in F_MUL0, F_MUL1, F_MUL2, then pushes to the queue.
// ----------------------------------------------------------------------------
module lph_front import lph_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned IdxW    = $clog2(CAPACITY)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            hold_i,
  output logic            busy_o,
  input  logic            mode_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  output logic            push_o,
  output req_t            req_o,
  output logic [IdxW-1:0] slot_o,
  input  logic            full_i
);

  front_state_e      state_q, state_d;
  req_t              req_q, req_d;
  logic [KeyW-1:0]   acc_q, acc_d;
  logic [HalfW-1:0]  mul_a, mul_b;
  logic [2*HalfW-1:0] prod;
  logic              accept;

  assign busy_o = (state_q != F_IDLE) || hold_i;
  assign accept = start_i && !busy_o;

  // Shared multiplier: one partial product per cycle
  assign prod = mul_a * mul_b;

  // Hold state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    acc_q <= acc_d;
  end

  // Sequence the partial products and the push
  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    acc_d   = acc_q;
    mul_a   = req_q.key[HalfW-1:0];
    mul_b   = HashMul[HalfW-1:0];
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          req_d.mode  = mode_i;
          req_d.key   = key_i;
          req_d.value = value_i;
          if (key_i == '0) begin
            req_d.kind = K_ZERO_KEY;
            state_d    = F_PUSH;
          end else if (mode_i && (value_i == '0)) begin
            req_d.kind = K_ZERO_VAL;
            state_d    = F_PUSH;
          end else begin
            req_d.kind = K_PROBE;
            state_d    = F_MUL0;
          end
        end
      end
      F_MUL0: begin
        acc_d   = prod;
        state_d = F_MUL1;
      end
      F_MUL1: begin
        mul_a = req_q.key[KeyW-1:HalfW];
        acc_d[KeyW-1:HalfW] = acc_q[KeyW-1:HalfW] + prod[HalfW-1:0];
        state_d = F_MUL2;
      end
      F_MUL2: begin
        mul_b = HashMul[KeyW-1:HalfW];
        acc_d[KeyW-1:HalfW] = acc_q[KeyW-1:HalfW] + prod[HalfW-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Fold the high half onto the low half and mask to the capacity
  assign slot_o = acc_q[IdxW-1:0] ^ acc_q[HashShift +: IdxW];
  assign req_o  = req_q;

endmodule

[rtl/lph_queue.sv]
// ----------------------------------------------------------------------------
// lph_queue
// Small FIFO between front end and back end; carries the request and its
// home slot so that either side can stall on its own.
// ----------------------------------------------------------------------------
module lph_queue import lph_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned IdxW    = $clog2(CAPACITY),
  localparam int unsigned PtrW    = $clog2(QueueDepth),
  localparam int unsigned CntW    = $clog2(QueueDepth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  req_t            req_i,
  input  logic [IdxW-1:0] slot_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output req_t            req_o,
  output logic [IdxW-1:0] slot_o
);

  req_t            req_q  [QueueDepth];
  logic [IdxW-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign req_o   = req_q[rd_ptr_q];
  assign slot_o  = slot_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      req_q[wr_ptr_q]  <= req_i;
      slot_q[wr_ptr_q] <= slot_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule

[rtl/lph_back.sv]
// ----------------------------------------------------------------------------
// lph_back
// Holds the slot memory, clears it after reset, probes linearly one slot per
// cycle and carries out lookups, inserts and updates.
// ----------------------------------------------------------------------------
module lph_back import lph_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned IdxW    = $clog2(CAPACITY),
  localparam int unsigned Half    = CAPACITY / 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            clearing_o,
  input  logic            empty_i,
  input  req_t            req_i,
  input  logic [IdxW-1:0] slot_i,
  output logic            pop_o,
  output logic            done_o,
  output logic [ValW-1:0] read_value_o,
  output status_e         status_o
);

  logic [KeyW+ValW-1:0] mem_q [CAPACITY];
  logic [KeyW+ValW-1:0] rdata_q, wdata;
  logic [IdxW-1:0]      raddr, waddr;
  logic                 we;

  back_state_e     state_q, state_d;
  req_t            req_q, req_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [IdxW-1:0] n_q, n_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic            done_q, done_d;
  logic [ValW-1:0] rv_q, rv_d;
  status_e         status_q, status_d;
  logic [KeyW-1:0] rd_key;
  logic [ValW-1:0] rd_val;

  assign rd_key = rdata_q[KeyW+ValW-1:ValW];
  assign rd_val = rdata_q[ValW-1:0];

  // Slot memory: key and value side by side, read data registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      cnt_q   <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    slot_q   <= slot_d;
    n_q      <= n_d;
    rv_q     <= rv_d;
    status_q <= status_d;
  end

  // Clear, pop, probe and decide
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    slot_d   = slot_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    done_d   = 1'b0;
    rv_d     = '0;
    status_d = status_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = slot_q;
    wdata    = {req_q.key, req_q.value};
    raddr    = IdxW'(slot_q + 1'b1);
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = IdxW'(clr_q + 1'b1);
        if (clr_q == IdxW'(CAPACITY - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        raddr = slot_i;
        if (!empty_i) begin
          pop_o  = 1'b1;
          req_d  = req_i;
          slot_d = slot_i;
          n_d    = '0;
          unique case (req_i.kind)
            K_ZERO_KEY: begin
              done_d   = 1'b1;
              status_d = ST_ZERO_KEY;
            end
            K_ZERO_VAL: begin
              done_d   = 1'b1;
              status_d = ST_ZERO_VALUE;
            end
            default: state_d = B_CHECK;
          endcase
        end
      end
      B_CHECK: begin
        if (rd_key == req_q.key) begin
          // Hit: return or overwrite the value
          done_d  = 1'b1;
          state_d = B_IDLE;
          if (req_q.mode) begin
            we       = 1'b1;
            status_d = ST_UPDATED;
          end else begin
            rv_d     = rd_val;
            status_d = ST_FOUND;
          end
        end else if (rd_key == '0) begin
          // Empty slot ends the probe: miss, reject or claim it
          done_d  = 1'b1;
          state_d = B_IDLE;
          if (!req_q.mode) begin
            status_d = ST_MISS;
          end else if (cnt_q >= IdxW'(Half)) begin
            status_d = ST_FULL;
          end else begin
            we       = 1'b1;
            cnt_d    = IdxW'(cnt_q + 1'b1);
            status_d = ST_INSERTED;
          end
        end else if (n_q == IdxW'(CAPACITY - 1)) begin
          // Every slot visited without an end
          done_d   = 1'b1;
          state_d  = B_IDLE;
          status_d = req_q.mode ? ST_FULL : ST_MISS;
        end else begin
          slot_d = IdxW'(slot_q + 1'b1);
          n_d    = IdxW'(n_q + 1'b1);
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign clearing_o   = (state_q == B_CLEAR);
  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign status_o     = status_q;

endmodule

[rtl/linear_probe_hash_map.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// The front end hashes each request with three passes of the shared 32x32
// multiplier and pushes it into the queue; the back end pops it and probes one
// slot per cycle through the registered read of the slot memory.
// The front takes a new request once it has pushed the last one; zero keys and
// zero values skip the multiplier. A full queue holds the front in its push.
// Reset: a clearing pass empties the slots; busy is held.
// ----------------------------------------------------------------------------
module linear_probe_hash_map import lph_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            mode_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  output logic            done_o,
  output logic [ValW-1:0] read_value_o,
  output logic [2:0]      status_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic            clearing;
  logic            push, full, pop, empty;
  req_t            fr_req, q_req;
  logic [IdxW-1:0] fr_slot, q_slot;
  status_e         status;

  // Accept and hash requests
  lph_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .hold_i  (clearing),
    .busy_o  (busy),
    .mode_i  (mode_i),
    .key_i   (key_i),
    .value_i (value_i),
    .push_o  (push),
    .req_o   (fr_req),
    .slot_o  (fr_slot),
    .full_i  (full)
  );

  // Decouple hashing from probing
  lph_queue #(.CAPACITY(CAPACITY)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (fr_req),
    .slot_i  (fr_slot),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .req_o   (q_req),
    .slot_o  (q_slot)
  );

  // Probe the table and answer
  lph_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .empty_i      (empty),
    .req_i        (q_req),
    .slot_i       (q_slot),
    .pop_o        (pop),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status)
  );

  assign status_o = status;

endmodule

[rtl/lph_checker.sv]
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks of the hash map: result encoding, busy after a request
// and busy as the slot clearing starts after reset.
// ----------------------------------------------------------------------------
module lph_checker import lph_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [ValW-1:0] read_value_o,
  input logic [2:0]      status_o
);

  // Drop the value on everything but a hit
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_FOUND)) |-> (read_value_o == '0))
    else $error("read value nonzero on a non-hit result");

  // Keep status codes in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_ZERO_KEY))
    else $error("status code out of range");

  // Hold busy once a request is taken
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted request");

  // Hold busy as the clearing pass starts after reset
  a_busy_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy)
    else $error("busy low at the start of the clearing pass");

endmodule

bind linear_probe_hash_map lph_checker u_lph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .read_value_o (read_value_o),
  .status_o     (status_o)
);

[test/linear_probe_hash_map_test.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_map_test
// Self-checking bench for the linear probing hash map. A local predictor keeps
// its own copy of the slot table and fill count and works out the reply to
// every accepted request. The bench runs directed corner cases, a random mix,
// a fill up to the half-load limit and traffic at that limit.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_test;
  import lph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap        = DefCapacity;
  localparam logic        ModeLookup = 1'b0;
  localparam logic        ModeStore  = 1'b1;
  localparam logic [63:0] AllOnes    = '1;
  localparam logic [63:0] TopBit     = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [ValW-1:0] read_value;
    status_e         status;
  } reply_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic            mode_i;
  logic [KeyW-1:0] key_i;
  logic [ValW-1:0] value_i;
  logic            done_o;
  logic [ValW-1:0] read_value_o;
  logic [2:0]      status_o;

  // Predictor state
  logic [KeyW-1:0] table_keys [Cap];
  logic [ValW-1:0] table_values [Cap];
  int unsigned     table_fill;

  reply_t          pending_replies [$];
  logic [KeyW-1:0] stored_keys [$];
  int unsigned     error_count;
  bit              idle_enabled;

  linear_probe_hash_map #(
    .CAPACITY(Cap)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .status_o    (status_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KeyW-1:0] fresh_key();
    logic [KeyW-1:0] k;
    do k = rand64(); while (k == '0);
    return k;
  endfunction

  // Home slot: multiply, fold the high half down, mask to the capacity
  function automatic int unsigned home_slot_of(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] h;
    h = k * HashMul;
    h = h ^ (h >> HashShift);
    return int'(h & 64'(Cap - 1));
  endfunction

  // Random nonzero key whose home slot is the given one
  function automatic logic [KeyW-1:0] key_homed_at(input int unsigned slot);
    logic [KeyW-1:0] k;
    do k = fresh_key(); while (home_slot_of(k) != slot);
    return k;
  endfunction

  // Work out the reply to one request and update the predicted table
  function automatic reply_t predict_reply(input logic m, input logic [KeyW-1:0] k,
                                           input logic [ValW-1:0] v);
    reply_t      r;
    int unsigned idx;
    bit          ended;
    r.read_value = '0;
    ended = 1'b0;
    idx = home_slot_of(k);
    // Probe linearly until a match or an empty slot, at most once around
    for (int unsigned n = 0; n < Cap; n++) begin
      if (table_keys[idx] == k || table_keys[idx] == '0) begin
        ended = 1'b1;
        break;
      end
      idx = (idx + 1) & (Cap - 1);
    end
    if (k == '0) begin
      r.status = ST_ZERO_KEY;
    end else if (m == ModeLookup) begin
      if (table_fill != 0 && ended && table_keys[idx] == k) begin
        r.read_value = table_values[idx];
        r.status = ST_FOUND;
      end else begin
        r.status = ST_MISS;
      end
    end else if (v == '0) begin
      r.status = ST_ZERO_VALUE;
    end else if (!ended) begin
      r.status = ST_FULL;
    end else if (table_keys[idx] == k) begin
      table_values[idx] = v;
      r.status = ST_UPDATED;
    end else if (2 * table_fill >= Cap) begin
      r.status = ST_FULL;
    end else begin
      table_keys[idx] = k;
      table_values[idx] = v;
      table_fill++;
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  // Send one request; start stays high when the next one follows at once
  task automatic send_request(input logic m, input logic [KeyW-1:0] k,
                              input logic [ValW-1:0] v);
    int unsigned gap;
    reply_t      r;
    bit          taken;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= m;
    key_i   <= k;
    value_i <= v;
    // Sample busy mid-cycle; the request is taken at the edge that follows
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    r = predict_reply(m, k, v);
    pending_replies.push_back(r);
    if (r.status == ST_INSERTED) stored_keys.push_back(k);
  endtask

  function automatic logic [KeyW-1:0] some_stored_key();
    if (stored_keys.size() == 0) return fresh_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // One random request drawn over every kind of request
  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30)      send_request(ModeStore, fresh_key(), rand64());
    else if (r < 45) send_request(ModeStore, some_stored_key(), rand64());
    else if (r < 68) send_request(ModeLookup, some_stored_key(), rand64());
    else if (r < 76) send_request(ModeLookup, fresh_key(), rand64());
    else if (r < 83) send_request(logic'($urandom_range(0, 1)), '0, rand64());
    else if (r < 89) send_request(ModeStore, ($urandom_range(0, 1) != 0) ?
                                  some_stored_key() : fresh_key(), '0);
    else if (r < 95) send_request(ModeStore,
                                  key_homed_at(home_slot_of(some_stored_key())), rand64());
    else             send_request(ModeLookup,
                                  key_homed_at(home_slot_of(some_stored_key())), rand64());
  endtask

  // Compare each reply with the oldest expectation
  always @(negedge clk_i) begin
    reply_t e;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status %0d value %h",
                                  status_o, read_value_o));
      end else begin
        e = pending_replies.pop_front();
        if (status_o !== e.status)
          report_mismatch($sformatf("status %0d, expected %s", status_o, e.status.name()));
        if (read_value_o !== e.read_value)
          report_mismatch($sformatf("read_value %h, expected %h", read_value_o,
                                    e.read_value));
      end
    end
  end

  // Empty table, zero key and zero value handling
  task automatic test_empty_and_zero_cases();
    send_request(ModeLookup, 64'd1, '0);
    send_request(ModeLookup, '0, AllOnes);
    send_request(ModeStore, '0, AllOnes);
    send_request(ModeStore, '0, '0);
    send_request(ModeStore, TopBit, '0);
  endtask

  // Inserts at the key and value extremes, lookups and updates
  task automatic test_insert_lookup_update();
    send_request(ModeStore, AllOnes, AllOnes);
    send_request(ModeStore, 64'd1, 64'd1);
    send_request(ModeStore, 64'd1, '0);
    send_request(ModeLookup, 64'd1, AllOnes);
    send_request(ModeLookup, AllOnes, '0);
    send_request(ModeStore, 64'd1, 64'h5555_5555_5555_5555);
    send_request(ModeLookup, 64'd1, '0);
    send_request(ModeLookup, TopBit, '0);
    send_request(ModeStore, TopBit, TopBit);
    send_request(ModeLookup, TopBit, '0);
  endtask

  // Keys homed at the last slot build a chain that wraps to slot zero
  task automatic test_wraparound_chain();
    logic [KeyW-1:0] chain [4];
    foreach (chain[i]) chain[i] = key_homed_at(Cap - 1);
    for (int i = 0; i < 3; i++) send_request(ModeStore, chain[i], rand64());
    send_request(ModeLookup, chain[2], '0);
    send_request(ModeLookup, chain[3], '0);
    send_request(ModeStore, chain[1], rand64());
  endtask

  task automatic test_random_mix();
    idle_enabled = 1'b1;
    repeat (60) random_request();
  endtask

  // Insert new keys up to the half-load limit, with stretches of no idling
  task automatic test_fill_to_half();
    int unsigned n;
    n = 0;
    while (2 * table_fill < Cap) begin
      idle_enabled = ((n / 64) % 2) == 0;
      send_request(ModeStore, fresh_key(), rand64());
      n++;
    end
    idle_enabled = 1'b1;
  endtask

  // New keys are rejected at the limit while updates still go through
  task automatic test_at_limit();
    repeat (8) send_request(ModeStore, fresh_key(), rand64());
    repeat (6) send_request(ModeStore, some_stored_key(), rand64());
    repeat (16) random_request();
  endtask

  // Stimulus
  initial begin
    int unsigned waited;
    error_count  = 0;
    table_fill   = 0;
    idle_enabled = 1'b0;
    foreach (table_keys[i]) begin
      table_keys[i]   = '0;
      table_values[i] = '0;
    end
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    mode_i  <= ModeLookup;
    key_i   <= '0;
    value_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_zero_cases();
    test_insert_lookup_update();
    test_wraparound_chain();
    test_random_mix();
    test_fill_to_half();
    test_at_limit();
    start <= 1'b0;

    // Drain outstanding replies, then watch for strays
    waited = 0;
    while (pending_replies.size() != 0 && waited < 4 * Cap + 200) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (64) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
rtl/lph_pkg.sv
rtl/lph_front.sv
rtl/lph_queue.sv
rtl/lph_back.sv
rtl/linear_probe_hash_map.sv
rtl/lph_checker.sv
test/linear_probe_hash_map_test.sv
